[sv/bel_pkg.sv]
`default_nettype none

package bel_pkg;

   // payload widths of the request and response beats
   localparam int FUNC_W        = 2;
   localparam int HANDLE_PORT_W = 32;
   localparam int VARIANT_W     = 16;
   localparam int POS_W         = 10;
   localparam int STATUS_W      = 2;
   localparam int ECOUNT_W      = 11;
   localparam int BCOUNT_W      = 7;

   // request function codes
   localparam logic [FUNC_W-1:0] FN_INSERT = 2'd0;
   localparam logic [FUNC_W-1:0] FN_REMOVE = 2'd1;
   localparam logic [FUNC_W-1:0] FN_READ   = 2'd2;

   // response status codes
   localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] ST_RANGE = 2'd1;
   localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;
   localparam logic [STATUS_W-1:0] ST_UNCOV = 2'd3;

endpackage

`default_nettype wire

[sv/bel_ram.sv]
`default_nettype none

module bel_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

[sv/bucketed_entry_list.sv]
`default_nettype none

// Packed handle list kept as contiguous batches sorted by variant id. One request is worked
// at a time; req_ready is high only while the sequencer is idle, and the response sits in an
// output register so the next request can be taken while it waits. A read scans the batch
// rows for the covering batch; an insert or remove also walks the later batches. A request
// rejected for range or a full store answers without a scan, one rejected for a full batch
// table after the scan. The block then returns to idle before it takes the next request,
// and a stalled response register adds its stall.
// The batch table and the handle store each have one registered read port, so the scan looks
// at one batch per cycle and the walk moves one entry per batch, fetching it and then moving
// it. Stores need no clearing pass after reset; the block is ready as soon as reset drops.
module bucketed_entry_list #(
   parameter int MAX_ENTRIES  = 1024,
   parameter int MAX_BATCHES  = 64,
   parameter int HANDLE_WIDTH = 32
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_valid,
   output logic                                      req_ready,
   input  wire logic [bel_pkg::FUNC_W-1:0]           req_func,
   input  wire logic [bel_pkg::HANDLE_PORT_W-1:0]    req_new_handle,
   input  wire logic [bel_pkg::VARIANT_W-1:0]        req_variant_id,
   input  wire logic [bel_pkg::POS_W-1:0]            req_position,
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_ready,
   output logic      [bel_pkg::STATUS_W-1:0]         rsp_status,
   output logic      [bel_pkg::HANDLE_PORT_W-1:0]    rsp_read_handle,
   output logic      [bel_pkg::VARIANT_W-1:0]        rsp_read_variant,
   output logic      [bel_pkg::ECOUNT_W-1:0]         rsp_entry_count,
   output logic      [bel_pkg::BCOUNT_W-1:0]         rsp_batch_count
);

   localparam int EW  = $clog2(MAX_ENTRIES + 1);
   localparam int AW  = $clog2(MAX_ENTRIES);
   localparam int BW  = $clog2(MAX_BATCHES + 1);
   localparam int BIW = (MAX_BATCHES > 1) ? $clog2(MAX_BATCHES) : 1;
   localparam int HW  = HANDLE_WIDTH;
   localparam int HPW = bel_pkg::HANDLE_PORT_W;
   localparam int VW  = bel_pkg::VARIANT_W;
   localparam int PW  = bel_pkg::POS_W;
   localparam int SW  = bel_pkg::STATUS_W;
   localparam int ECW = bel_pkg::ECOUNT_W;
   localparam int BCW = bel_pkg::BCOUNT_W;

   typedef struct packed {
      logic [VW-1:0] variant;
      logic [EW-1:0] head;
      logic [EW-1:0] tail;
   } row_type;

   localparam int RW = $bits(row_type);

   // sequencer states
   localparam logic [3:0] S_IDLE     = 4'd0;
   localparam logic [3:0] S_SCAN     = 4'd1;
   localparam logic [3:0] S_SCAN_CHK = 4'd2;
   localparam logic [3:0] S_DECIDE   = 4'd3;
   localparam logic [3:0] S_REM_HEAD = 4'd4;
   localparam logic [3:0] S_REM_PUT  = 4'd5;
   localparam logic [3:0] S_WALK     = 4'd6;
   localparam logic [3:0] S_W_ENT    = 4'd7;
   localparam logic [3:0] S_W_MOV    = 4'd8;
   localparam logic [3:0] S_FINAL    = 4'd9;
   localparam logic [3:0] S_RD_ISSUE = 4'd10;
   localparam logic [3:0] S_RD_TAKE  = 4'd11;
   localparam logic [3:0] S_DONE     = 4'd12;

   logic [3:0]    state_ff, state_in;
   logic [1:0]    func_ff, func_in;
   logic [HW-1:0] hnd_ff, hnd_in;
   logic [VW-1:0] var_ff, var_in;
   logic [PW-1:0] pos_ff, pos_in;
   logic [EW-1:0] ue_ff, ue_in;
   logic [BW-1:0] ub_ff, ub_in;
   logic [BW-1:0] slot_ff, slot_in;
   logic          found_ff, found_in;
   row_type       srow_ff, srow_in;
   logic          shift_ff, shift_in;
   logic [BW-1:0] cur_ff, cur_in;
   logic [BW-1:0] cnt_ff, cnt_in;
   logic [SW-1:0] status_ff, status_in;
   logic [HW-1:0] rdh_ff, rdh_in;
   logic [VW-1:0] rdv_ff, rdv_in;

   logic           rsp_valid_ff, rsp_valid_in;
   logic [SW-1:0]  rsp_status_ff, rsp_status_in;
   logic [HPW-1:0] rsp_handle_ff, rsp_handle_in;
   logic [VW-1:0]  rsp_variant_ff, rsp_variant_in;
   logic [ECW-1:0] rsp_ecount_ff, rsp_ecount_in;
   logic [BCW-1:0] rsp_bcount_ff, rsp_bcount_in;

   // memory ports
   logic           row_we, row_re;
   logic [BIW-1:0] row_waddr, row_raddr;
   logic [RW-1:0]  row_wdata, row_rdata;
   logic           ent_we, ent_re;
   logic [AW-1:0]  ent_waddr, ent_raddr;
   logic [HW-1:0]  ent_wdata, ent_rdata;

   bel_ram #(
      .WIDTH (RW),
      .DEPTH (MAX_BATCHES)
   ) u_batch_ram (
      .clock   (clock),
      .wr_en   (row_we),
      .wr_addr (row_waddr),
      .wr_data (row_wdata),
      .rd_en   (row_re),
      .rd_addr (row_raddr),
      .rd_data (row_rdata)
   );

   bel_ram #(
      .WIDTH (HW),
      .DEPTH (MAX_ENTRIES)
   ) u_entry_ram (
      .clock   (clock),
      .wr_en   (ent_we),
      .wr_addr (ent_waddr),
      .wr_data (ent_wdata),
      .rd_en   (ent_re),
      .rd_addr (ent_raddr),
      .rd_data (ent_rdata)
   );

   row_type       rrow;
   logic          ins;
   logic          scan_go;
   logic          fresh;
   logic          rsp_free;
   logic [EW-1:0] start;
   row_type       step_row;
   logic [BW-1:0] cur_next;

   assign rrow     = row_type'(row_rdata);
   assign ins      = (func_ff == bel_pkg::FN_INSERT);
   assign rsp_free = !rsp_valid_ff || rsp_ready;
   assign fresh    = !found_ff || (srow_ff.variant != var_ff);
   assign start    = found_ff ? srow_ff.head : ue_ff;
   assign cur_next = ins ? BW'(cur_ff - BW'(1)) : BW'(cur_ff + BW'(1));

   // shared compare: keep scanning while the batch lies before the target
   assign scan_go = ins ? (rrow.variant < var_ff)
                        : (32'(rrow.tail) <= 32'(pos_ff));

   // shared step unit: move a batch window up one place on insert, down one on remove
   always_comb begin
      step_row         = rrow;
      step_row.head    = ins ? EW'(rrow.head + EW'(1)) : EW'(rrow.head - EW'(1));
      step_row.tail    = ins ? EW'(rrow.tail + EW'(1)) : EW'(rrow.tail - EW'(1));
   end

   // sequencer
   always_comb begin
      state_in  = state_ff;
      func_in   = func_ff;
      hnd_in    = hnd_ff;
      var_in    = var_ff;
      pos_in    = pos_ff;
      ue_in     = ue_ff;
      ub_in     = ub_ff;
      slot_in   = slot_ff;
      found_in  = found_ff;
      srow_in   = srow_ff;
      shift_in  = shift_ff;
      cur_in    = cur_ff;
      cnt_in    = cnt_ff;
      status_in = status_ff;
      rdh_in    = rdh_ff;
      rdv_in    = rdv_ff;

      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_status_in  = rsp_status_ff;
      rsp_handle_in  = rsp_handle_ff;
      rsp_variant_in = rsp_variant_ff;
      rsp_ecount_in  = rsp_ecount_ff;
      rsp_bcount_in  = rsp_bcount_ff;

      row_we    = 1'b0;
      row_waddr = '0;
      row_wdata = '0;
      row_re    = 1'b0;
      row_raddr = '0;
      ent_we    = 1'b0;
      ent_waddr = '0;
      ent_wdata = '0;
      ent_re    = 1'b0;
      ent_raddr = '0;

      req_ready = (state_ff == S_IDLE);

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               func_in   = req_func;
               hnd_in    = HW'(req_new_handle);
               var_in    = req_variant_id;
               pos_in    = req_position;
               slot_in   = '0;
               rdh_in    = '0;
               rdv_in    = '0;
               status_in = bel_pkg::ST_OK;
               state_in  = S_DONE;
               if (req_func == bel_pkg::FN_INSERT) begin
                  if (32'(ue_ff) >= 32'(MAX_ENTRIES)) begin
                     status_in = bel_pkg::ST_FULL;
                  end else begin
                     state_in = S_SCAN;
                  end
               end else if (req_func == bel_pkg::FN_REMOVE || req_func == bel_pkg::FN_READ) begin
                  if (32'(req_position) >= 32'(ue_ff)) begin
                     status_in = bel_pkg::ST_RANGE;
                  end else begin
                     state_in = S_SCAN;
                  end
               end
            end
         end

         // first batch of the scan
         S_SCAN: begin
            if (slot_ff == ub_ff) begin
               found_in = 1'b0;
               state_in = S_DECIDE;
            end else begin
               row_re    = 1'b1;
               row_raddr = BIW'(slot_ff);
               state_in  = S_SCAN_CHK;
            end
         end

         // one batch per cycle, next row fetched while this one is compared
         S_SCAN_CHK: begin
            if (scan_go) begin
               slot_in = BW'(slot_ff + BW'(1));
               if (BW'(slot_ff + BW'(1)) == ub_ff) begin
                  found_in = 1'b0;
                  state_in = S_DECIDE;
               end else begin
                  row_re    = 1'b1;
                  row_raddr = BIW'(slot_ff + BW'(1));
               end
            end else begin
               found_in = 1'b1;
               srow_in  = rrow;
               state_in = S_DECIDE;
            end
         end

         S_DECIDE: begin
            if (ins) begin
               if (fresh && (32'(ub_ff) >= 32'(MAX_BATCHES))) begin
                  status_in = bel_pkg::ST_FULL;
                  state_in  = S_DONE;
               end else begin
                  shift_in = fresh;
                  cnt_in   = BW'(ub_ff - slot_ff - BW'(fresh ? 0 : 1));
                  cur_in   = BW'(ub_ff - BW'(1));
                  state_in = S_WALK;
               end
            end else if (!found_ff) begin
               status_in = bel_pkg::ST_UNCOV;
               state_in  = S_DONE;
            end else if (func_ff == bel_pkg::FN_REMOVE) begin
               shift_in = (srow_ff.head == EW'(srow_ff.tail - EW'(1)));
               state_in = S_REM_HEAD;
            end else begin
               state_in = S_RD_ISSUE;
            end
         end

         // remove: fetch last entry of the covering batch
         S_REM_HEAD: begin
            ent_re    = 1'b1;
            ent_raddr = AW'(srow_ff.tail - EW'(1));
            state_in  = S_REM_PUT;
         end

         // remove: fill the hole, shrink the batch unless it empties
         S_REM_PUT: begin
            ent_we    = 1'b1;
            ent_waddr = AW'(pos_ff);
            ent_wdata = ent_rdata;
            if (!shift_ff) begin
               row_we         = 1'b1;
               row_waddr      = BIW'(slot_ff);
               row_wdata      = {srow_ff.variant, srow_ff.head, EW'(srow_ff.tail - EW'(1))};
            end
            cnt_in   = BW'(ub_ff - slot_ff - BW'(1));
            cur_in   = BW'(slot_ff + BW'(1));
            state_in = S_WALK;
         end

         S_WALK: begin
            if (cnt_ff == '0) begin
               state_in = S_FINAL;
            end else begin
               row_re    = 1'b1;
               row_raddr = BIW'(cur_ff);
               state_in  = S_W_ENT;
            end
         end

         // fetch the entry that moves across this batch
         S_W_ENT: begin
            ent_re    = 1'b1;
            ent_raddr = ins ? AW'(rrow.head) : AW'(rrow.tail - EW'(1));
            state_in  = S_W_MOV;
         end

         // move the entry, write back the shifted window, fetch the next batch if one is left
         S_W_MOV: begin
            ent_we    = 1'b1;
            ent_waddr = ins ? AW'(rrow.tail) : AW'(rrow.head - EW'(1));
            ent_wdata = ent_rdata;
            row_we    = 1'b1;
            row_wdata = step_row;
            if (!shift_ff) begin
               row_waddr = BIW'(cur_ff);
            end else if (ins) begin
               row_waddr = BIW'(cur_ff + BW'(1));
            end else begin
               row_waddr = BIW'(cur_ff - BW'(1));
            end
            cnt_in = BW'(cnt_ff - BW'(1));
            cur_in = cur_next;
            if (cnt_ff != BW'(1)) begin
               row_re    = 1'b1;
               row_raddr = BIW'(cur_next);
               state_in  = S_W_ENT;
            end else begin
               state_in = S_FINAL;
            end
         end

         S_FINAL: begin
            if (ins) begin
               ent_we    = 1'b1;
               ent_waddr = shift_ff ? AW'(start) : AW'(srow_ff.tail);
               ent_wdata = hnd_ff;
               row_we    = 1'b1;
               row_waddr = BIW'(slot_ff);
               row_wdata = shift_ff ? {var_ff, start, EW'(start + EW'(1))}
                                    : {srow_ff.variant, srow_ff.head,
                                       EW'(srow_ff.tail + EW'(1))};
               ue_in     = EW'(ue_ff + EW'(1));
               ub_in     = BW'(ub_ff + BW'(shift_ff));
            end else begin
               ue_in = EW'(ue_ff - EW'(1));
               ub_in = BW'(ub_ff - BW'(shift_ff));
            end
            state_in = S_DONE;
         end

         S_RD_ISSUE: begin
            ent_re    = 1'b1;
            ent_raddr = AW'(pos_ff);
            state_in  = S_RD_TAKE;
         end

         S_RD_TAKE: begin
            rdh_in   = ent_rdata;
            rdv_in   = srow_ff.variant;
            state_in = S_DONE;
         end

         // load the response register once it is free
         S_DONE: begin
            if (rsp_free) begin
               rsp_valid_in   = 1'b1;
               rsp_status_in  = status_ff;
               rsp_handle_in  = HPW'(rdh_ff);
               rsp_variant_in = rdv_ff;
               rsp_ecount_in  = ECW'(ue_ff);
               rsp_bcount_in  = BCW'(ub_ff);
               state_in       = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         ue_ff        <= '0;
         ub_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ue_ff        <= ue_in;
         ub_ff        <= ub_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // working and response payload
   always_ff @(posedge clock) begin
      func_ff        <= func_in;
      hnd_ff         <= hnd_in;
      var_ff         <= var_in;
      pos_ff         <= pos_in;
      slot_ff        <= slot_in;
      found_ff       <= found_in;
      srow_ff        <= srow_in;
      shift_ff       <= shift_in;
      cur_ff         <= cur_in;
      cnt_ff         <= cnt_in;
      status_ff      <= status_in;
      rdh_ff         <= rdh_in;
      rdv_ff         <= rdv_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_handle_ff  <= rsp_handle_in;
      rsp_variant_ff <= rsp_variant_in;
      rsp_ecount_ff  <= rsp_ecount_in;
      rsp_bcount_ff  <= rsp_bcount_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_read_handle  = rsp_handle_ff;
   assign rsp_read_variant = rsp_variant_ff;
   assign rsp_entry_count  = rsp_ecount_ff;
   assign rsp_batch_count  = rsp_bcount_ff;

   // counts stay within the store sizes
   a_counts_bounded: assert property (@(posedge clock) disable iff (reset)
      (32'(ue_ff) <= 32'(MAX_ENTRIES)) && (32'(ub_ff) <= 32'(MAX_BATCHES)))
      else $error("entry or batch count beyond store size");

   // never more batches than entries, since no empty batch is kept
   a_batches_nonempty: assert property (@(posedge clock) disable iff (reset)
      32'(ub_ff) <= 32'(ue_ff))
      else $error("more batches than entries");

   // every valid position is covered by a batch
   a_no_uncovered: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status != bel_pkg::ST_UNCOV))
      else $error("position not covered by any batch");

   // a finished request reaches the response register
   a_done_loads: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DONE) && rsp_free |=> rsp_valid && (state_ff == S_IDLE))
      else $error("finished request not presented");

endmodule

`default_nettype wire

[bench/bucketed_entry_list_tb.sv]
`timescale 1ns / 1ps

module bucketed_entry_list_tb;

   localparam int DEPTH     = 1024;
   localparam int NBATCH    = 64;
   localparam int HANDLE_W  = 32;
   localparam int CYC_LIMIT = 3_000_000;
   localparam int TAIL_CYC  = 300;
   localparam int MAX_LINES = 50;

   // spare function code, decoded as a no-op by the block
   localparam logic [bel_pkg::FUNC_W-1:0] FN_UNUSED = 2'd3;

   // how a random run decides to stop
   localparam int RUN_FIXED    = 0;
   localparam int RUN_TO_FULL  = 1;
   localparam int RUN_TO_EMPTY = 2;

   // receiver stall styles
   localparam int STALL_NONE = 0;
   localparam int STALL_COIN = 1;
   localparam int STALL_HOLD = 2;

   typedef struct packed {
      logic [bel_pkg::STATUS_W-1:0]      status;
      logic [bel_pkg::HANDLE_PORT_W-1:0] handle;
      logic [bel_pkg::VARIANT_W-1:0]     variant;
      logic [bel_pkg::ECOUNT_W-1:0]      ecount;
      logic [bel_pkg::BCOUNT_W-1:0]      bcount;
   } bel_rsp_type;

   typedef struct {
      logic [bel_pkg::FUNC_W-1:0]        func;
      logic [bel_pkg::HANDLE_PORT_W-1:0] handle;
      logic [bel_pkg::VARIANT_W-1:0]     variant;
      logic [bel_pkg::POS_W-1:0]         pos;
      bit                                typed;
      bel_rsp_type                       want;
   } dir_row_type;

   logic                              clock            = 1'b0;
   logic                              reset            = 1'b1;
   logic                              req_valid        = 1'b0;
   logic                              req_ready;
   logic [bel_pkg::FUNC_W-1:0]        req_func         = bel_pkg::FN_READ;
   logic [bel_pkg::HANDLE_PORT_W-1:0] req_new_handle   = '0;
   logic [bel_pkg::VARIANT_W-1:0]     req_variant_id   = '0;
   logic [bel_pkg::POS_W-1:0]         req_position     = '0;
   logic                              rsp_valid;
   logic                              rsp_ready        = 1'b0;
   logic [bel_pkg::STATUS_W-1:0]      rsp_status;
   logic [bel_pkg::HANDLE_PORT_W-1:0] rsp_read_handle;
   logic [bel_pkg::VARIANT_W-1:0]     rsp_read_variant;
   logic [bel_pkg::ECOUNT_W-1:0]      rsp_entry_count;
   logic [bel_pkg::BCOUNT_W-1:0]      rsp_batch_count;

   // shadow copy of the list contents
   logic [HANDLE_W-1:0]           shadow_ent [0:DEPTH-1];
   logic [bel_pkg::VARIANT_W-1:0] shadow_var [0:NBATCH-1];
   int                            shadow_lo  [0:NBATCH-1];
   int                            shadow_hi  [0:NBATCH-1];
   int                            n_ent = 0;
   int                            n_bat = 0;

   bel_rsp_type owed_rsp_q[$];

   int err_cnt      = 0;
   int rsp_seen     = 0;
   int cyc_cnt      = 0;
   int burst_left   = 0;
   int ins_cnt      = 0;
   int rem_cnt      = 0;
   int rd_cnt       = 0;
   int range_cnt    = 0;
   int ent_full_cnt = 0;
   int bat_full_cnt = 0;
   int peak_ent     = 0;
   int peak_bat     = 0;
   int stall_mode   = STALL_NONE;
   int mode_left    = 0;
   int hold_left    = 0;

   // directed rows: a handful carry a hand-typed answer, the rest go to the predictor
   dir_row_type dir_tab [24] = '{
      '{bel_pkg::FN_READ,   32'h0000_0000, 16'h0000, 10'd0,   1'b1,
        '{bel_pkg::ST_RANGE, 32'h0, 16'h0, 11'd0, 7'd0}},
      '{bel_pkg::FN_REMOVE, 32'h0000_0000, 16'h0000, 10'h3FF, 1'b1,
        '{bel_pkg::ST_RANGE, 32'h0, 16'h0, 11'd0, 7'd0}},
      '{FN_UNUSED,          32'hFFFF_FFFF, 16'hFFFF, 10'h3FF, 1'b1,
        '{bel_pkg::ST_OK, 32'h0, 16'h0, 11'd0, 7'd0}},
      '{bel_pkg::FN_INSERT, 32'hFFFF_FFFF, 16'hFFFF, 10'h3FF, 1'b1,
        '{bel_pkg::ST_OK, 32'h0, 16'h0, 11'd1, 7'd1}},
      '{bel_pkg::FN_READ,   32'h0000_0000, 16'h0000, 10'd0,   1'b1,
        '{bel_pkg::ST_OK, 32'hFFFF_FFFF, 16'hFFFF, 11'd1, 7'd1}},
      '{bel_pkg::FN_INSERT, 32'h0000_0000, 16'h0000, 10'd0,   1'b1,
        '{bel_pkg::ST_OK, 32'h0, 16'h0, 11'd2, 7'd2}},
      '{bel_pkg::FN_INSERT, 32'h1234_5678, 16'h8000, 10'd0,   1'b0, '0},
      '{bel_pkg::FN_INSERT, 32'hA5A5_A5A5, 16'h0000, 10'd0,   1'b0, '0},
      '{bel_pkg::FN_INSERT, 32'h5A5A_5A5A, 16'h8000, 10'd0,   1'b0, '0},
      '{bel_pkg::FN_INSERT, 32'h0000_0001, 16'h7FFF, 10'd0,   1'b0, '0},
      '{bel_pkg::FN_READ,   32'h0000_0000, 16'h0000, 10'd0,   1'b0, '0},
      '{bel_pkg::FN_READ,   32'h0000_0000, 16'h0000, 10'd1,   1'b0, '0},
      '{bel_pkg::FN_READ,   32'h0000_0000, 16'h0000, 10'd2,   1'b0, '0},
      '{bel_pkg::FN_READ,   32'h0000_0000, 16'h0000, 10'd3,   1'b0, '0},
      '{bel_pkg::FN_READ,   32'h0000_0000, 16'h0000, 10'd4,   1'b0, '0},
      '{bel_pkg::FN_READ,   32'h0000_0000, 16'h0000, 10'd5,   1'b0, '0},
      '{bel_pkg::FN_READ,   32'h0000_0000, 16'h0000, 10'd6,   1'b1,
        '{bel_pkg::ST_RANGE, 32'h0, 16'h0, 11'd6, 7'd4}},
      '{bel_pkg::FN_REMOVE, 32'h0000_0000, 16'h0000, 10'd0,   1'b0, '0},
      '{bel_pkg::FN_REMOVE, 32'hFFFF_FFFF, 16'hFFFF, 10'd4,   1'b0, '0},
      '{bel_pkg::FN_REMOVE, 32'h0000_0000, 16'h0000, 10'd0,   1'b0, '0},
      '{bel_pkg::FN_READ,   32'h0000_0000, 16'h0000, 10'd0,   1'b0, '0},
      '{bel_pkg::FN_READ,   32'h0000_0000, 16'h0000, 10'd2,   1'b0, '0},
      '{FN_UNUSED,          32'h0000_0000, 16'h0000, 10'd0,   1'b0, '0},
      '{bel_pkg::FN_READ,   32'h0000_0000, 16'h0000, 10'h3FF, 1'b0, '0}
   };

   bucketed_entry_list #(
      .MAX_ENTRIES  (DEPTH),
      .MAX_BATCHES  (NBATCH),
      .HANDLE_WIDTH (HANDLE_W)
   ) i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_func         (req_func),
      .req_new_handle   (req_new_handle),
      .req_variant_id   (req_variant_id),
      .req_position     (req_position),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_status       (rsp_status),
      .rsp_read_handle  (rsp_read_handle),
      .rsp_read_variant (rsp_read_variant),
      .rsp_entry_count  (rsp_entry_count),
      .rsp_batch_count  (rsp_batch_count)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   // insert into the shadow list: rotate later batches up by one, append to own batch
   function automatic logic [bel_pkg::STATUS_W-1:0] list_insert(
      logic [HANDLE_W-1:0] h, logic [bel_pkg::VARIANT_W-1:0] v);
      int  slot;
      int  i;
      int  start;
      bit  fresh;
      if (n_ent >= DEPTH) return bel_pkg::ST_FULL;
      slot = 0;
      while (slot < n_bat && shadow_var[slot] < v) slot++;
      fresh = (slot == n_bat) || (shadow_var[slot] != v);
      if (fresh) begin
         if (n_bat >= NBATCH) return bel_pkg::ST_FULL;
         start = (slot < n_bat) ? shadow_lo[slot] : n_ent;
         for (i = n_bat; i > slot; i--) begin
            shadow_var[i] = shadow_var[i-1];
            shadow_lo[i]  = shadow_lo[i-1];
            shadow_hi[i]  = shadow_hi[i-1];
         end
         shadow_var[slot] = v;
         shadow_lo[slot]  = start;
         shadow_hi[slot]  = start;
         n_bat++;
      end
      n_ent++;
      for (i = n_bat - 1; i > slot; i--) begin
         shadow_ent[shadow_hi[i]] = shadow_ent[shadow_lo[i]];
         shadow_lo[i]++;
         shadow_hi[i]++;
      end
      shadow_ent[shadow_hi[slot]] = h;
      shadow_hi[slot]++;
      return bel_pkg::ST_OK;
   endfunction

   // remove from the shadow list: backfill from own batch, shift later batches down
   function automatic logic [bel_pkg::STATUS_W-1:0] list_remove(int p);
      int slot;
      int i;
      bit empty;
      if (p >= n_ent) return bel_pkg::ST_RANGE;
      slot = 0;
      while (slot < n_bat && shadow_hi[slot] <= p) slot++;
      if (slot == n_bat) return bel_pkg::ST_UNCOV;
      shadow_ent[p] = shadow_ent[shadow_hi[slot]-1];
      shadow_hi[slot]--;
      empty = (shadow_lo[slot] == shadow_hi[slot]);
      for (i = slot + 1; i < n_bat; i++) begin
         shadow_ent[shadow_lo[i]-1] = shadow_ent[shadow_hi[i]-1];
         shadow_lo[i]--;
         shadow_hi[i]--;
      end
      n_ent--;
      if (empty) begin
         for (i = slot; i + 1 < n_bat; i++) begin
            shadow_var[i] = shadow_var[i+1];
            shadow_lo[i]  = shadow_lo[i+1];
            shadow_hi[i]  = shadow_hi[i+1];
         end
         n_bat--;
      end
      return bel_pkg::ST_OK;
   endfunction

   // full answer for one request, updating the shadow list
   function automatic bel_rsp_type list_apply(logic [bel_pkg::FUNC_W-1:0] f,
                                              logic [bel_pkg::HANDLE_PORT_W-1:0] h,
                                              logic [bel_pkg::VARIANT_W-1:0] v,
                                              logic [bel_pkg::POS_W-1:0] p);
      bel_rsp_type r;
      int          slot;
      r = '0;
      case (f)
         bel_pkg::FN_INSERT: r.status = list_insert(h, v);
         bel_pkg::FN_REMOVE: r.status = list_remove(int'(p));
         bel_pkg::FN_READ: begin
            if (int'(p) >= n_ent) begin
               r.status = bel_pkg::ST_RANGE;
            end else begin
               slot = 0;
               while (slot < n_bat && shadow_hi[slot] <= int'(p)) slot++;
               if (slot == n_bat) begin
                  r.status = bel_pkg::ST_UNCOV;
               end else begin
                  r.handle  = shadow_ent[p];
                  r.variant = shadow_var[slot];
               end
            end
         end
         default: r.status = bel_pkg::ST_OK;
      endcase
      r.ecount = n_ent[bel_pkg::ECOUNT_W-1:0];
      r.bcount = n_bat[bel_pkg::BCOUNT_W-1:0];
      return r;
   endfunction

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      if (err_cnt < MAX_LINES)
         $display("mismatch at beat %0d: %s got %h want %h", rsp_seen, what, got, want);
      err_cnt++;
   endtask

   // one request beat; the sender runs in bursts with idle gaps in between
   task automatic send_req(logic [bel_pkg::FUNC_W-1:0] f,
                           logic [bel_pkg::HANDLE_PORT_W-1:0] h,
                           logic [bel_pkg::VARIANT_W-1:0] v, logic [bel_pkg::POS_W-1:0] p,
                           bit typed, bel_rsp_type typed_want);
      int          gap;
      bel_rsp_type got;
      bel_rsp_type owed;
      if (burst_left == 0) begin
         gap = $urandom_range(1, 8);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
         burst_left = ($urandom_range(0, 9) < 2) ? $urandom_range(40, 150)
                                                : $urandom_range(1, 12);
      end
      req_valid      <= 1'b1;
      req_func       <= f;
      req_new_handle <= h;
      req_variant_id <= v;
      req_position   <= p;
      do @(posedge clock); while (!req_ready);
      burst_left--;
      got = list_apply(f, h, v, p);
      owed = typed ? typed_want : got;
      owed_rsp_q = {owed_rsp_q, owed};
      // run statistics
      case (f)
         bel_pkg::FN_INSERT: ins_cnt++;
         bel_pkg::FN_REMOVE: rem_cnt++;
         bel_pkg::FN_READ:   rd_cnt++;
         default:   ;
      endcase
      if (got.status == bel_pkg::ST_RANGE) range_cnt++;
      if (got.status == bel_pkg::ST_FULL) begin
         if (n_ent == DEPTH) ent_full_cnt++;
         else bat_full_cnt++;
      end
      if (n_ent > peak_ent) peak_ent = n_ent;
      if (n_bat > peak_bat) peak_bat = n_bat;
   endtask

   // random traffic with a chosen mix of operations and share of new variant keys
   task automatic run_mix(int max_items, int pct_ins, int pct_rem, int pct_fresh, int stop_at);
      int                            k;
      int                            r;
      int                            full_mark;
      logic [bel_pkg::FUNC_W-1:0]    f;
      logic [bel_pkg::VARIANT_W-1:0] v;
      logic [bel_pkg::POS_W-1:0]     p;
      full_mark = ent_full_cnt;
      for (k = 0; k < max_items; k++) begin
         if (stop_at == RUN_TO_FULL && ent_full_cnt - full_mark >= 25) break;
         if (stop_at == RUN_TO_EMPTY && n_ent == 0) break;
         r = $urandom_range(0, 99);
         if (r < pct_ins) f = bel_pkg::FN_INSERT;
         else if (r < pct_ins + pct_rem) f = bel_pkg::FN_REMOVE;
         else if ($urandom_range(0, 19) == 0) f = FN_UNUSED;
         else f = bel_pkg::FN_READ;
         if (n_bat == 0 || $urandom_range(0, 99) < pct_fresh)
            v = bel_pkg::VARIANT_W'($urandom_range(0, 65535));
         else
            v = shadow_var[$urandom_range(0, n_bat - 1)];
         // mostly valid positions, some at the boundary and some anywhere
         case ($urandom_range(0, 9))
            0: p = bel_pkg::POS_W'($urandom_range(0, DEPTH - 1));
            1: p = bel_pkg::POS_W'(n_ent);
            default: p = (n_ent > 0) ? bel_pkg::POS_W'($urandom_range(0, n_ent - 1))
                                     : bel_pkg::POS_W'($urandom_range(0, DEPTH - 1));
         endcase
         send_req(f, $urandom(), v, p, 1'b0, '0);
      end
   endtask

   // receiver: switches between no stalls, coin-flip stalls and long holds
   always @(posedge clock) begin
      if (mode_left == 0) begin
         mode_left  <= $urandom_range(64, 400);
         stall_mode <= $urandom_range(STALL_NONE, STALL_HOLD);
      end else begin
         mode_left <= mode_left - 1;
      end
      case (stall_mode)
         STALL_NONE: rsp_ready <= 1'b1;
         STALL_COIN: rsp_ready <= 1'($urandom_range(0, 1));
         default: begin
            if (hold_left == 0) begin
               hold_left <= $urandom_range(1, 12);
               rsp_ready <= ~rsp_ready;
            end else begin
               hold_left <= hold_left - 1;
            end
         end
      endcase
   end

   // response check against the oldest owed answer
   always @(posedge clock) begin
      bel_rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (owed_rsp_q.size() == 0) begin
            report_mismatch("beat with nothing owed", 32'(rsp_status), 32'h0);
         end else begin
            want = owed_rsp_q.pop_front();
            if (rsp_status != want.status)
               report_mismatch("status", 32'(rsp_status), 32'(want.status));
            if (rsp_read_handle != want.handle)
               report_mismatch("read_handle", rsp_read_handle, want.handle);
            if (rsp_read_variant != want.variant)
               report_mismatch("read_variant", 32'(rsp_read_variant), 32'(want.variant));
            if (rsp_entry_count != want.ecount)
               report_mismatch("entry_count", 32'(rsp_entry_count), 32'(want.ecount));
            if (rsp_batch_count != want.bcount)
               report_mismatch("batch_count", 32'(rsp_batch_count), 32'(want.bcount));
         end
         rsp_seen++;
      end
   end

   // watchdog
   always @(posedge clock) begin
      cyc_cnt <= cyc_cnt + 1;
      if (cyc_cnt > CYC_LIMIT) begin
         $display("timeout after %0d cycles, %0d beats still owed", cyc_cnt, owed_rsp_q.size());
         $display("TEST FAILED");
         $finish;
      end
   end

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed rows
      foreach (dir_tab[i])
         send_req(dir_tab[i].func, dir_tab[i].handle, dir_tab[i].variant, dir_tab[i].pos,
                  dir_tab[i].typed, dir_tab[i].want);

      // many new keys to fill the batch table, then fill the store, drain part of it and end with a mixed run
      run_mix(250, 55, 25, 80, RUN_FIXED);
      run_mix(1400, 95, 2, 3, RUN_TO_FULL);
      run_mix(500, 4, 86, 30, RUN_TO_EMPTY);
      run_mix(80, 40, 40, 50, RUN_FIXED);
      req_valid <= 1'b0;

      while (owed_rsp_q.size() != 0) @(posedge clock);
      repeat (TAIL_CYC) @(posedge clock);
      if (owed_rsp_q.size() != 0)
         report_mismatch("beats never returned", 32'(owed_rsp_q.size()), 32'h0);

      $display("ran %0d inserts, %0d removes, %0d reads; %0d beats checked in %0d cycles",
               ins_cnt, rem_cnt, rd_cnt, rsp_seen, cyc_cnt);
      $display("peak %0d entries, %0d batches; rejected %0d full, %0d table, %0d range",
               peak_ent, peak_bat, ent_full_cnt, bat_full_cnt, range_cnt);
      if (err_cnt == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("%0d mismatches", err_cnt);
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
